// ----- rtl/pal_pkg.sv -----
package pal_pkg;

	// field widths fixed by the request and result formats
	localparam int unsigned REQ_W  = 2;
	localparam int unsigned POS_W  = 5;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned IDX_W  = 4;
	localparam int unsigned LEN_W  = 5;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

	// what every cell of the chain does this cycle
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE
	} cell_op_t;

	// control broadcast along the chain
	typedef struct packed {
		cell_op_t                 op;
		logic [POS_W-1:0]         slot;
		logic signed [VAL_W-1:0]  data;
	} cell_ctrl_t;

endpackage

// ----- rtl/pal_cell.sv -----
module pal_cell #(
	parameter int unsigned SLOT = 0,
	parameter int unsigned CW   = 5
) (
	input  logic                               clk,
	input  pal_pkg::cell_ctrl_t                ctrl,
	input  logic [CW-1:0]                      count,
	input  logic signed [pal_pkg::VAL_W-1:0]   left_entry,
	input  logic signed [pal_pkg::VAL_W-1:0]   right_entry,
	output logic signed [pal_pkg::VAL_W-1:0]   entry,
	output logic                               match
);
	import pal_pkg::*;

	logic signed [VAL_W-1:0] entry_q;
	logic                    above_slot;
	logic                    at_slot;
	logic                    occupied;

	// position of this cell against the addressed slot and the fill level
	assign above_slot = SLOT > 32'(ctrl.slot);
	assign at_slot    = SLOT == 32'(ctrl.slot);
	assign occupied   = 32'(count) > SLOT;

	// shift up on insert, shift down on delete, load at the slot
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INSERT: begin
				if (above_slot) begin
					entry_q <= left_entry;
				end else if (at_slot) begin
					entry_q <= ctrl.data;
				end
			end
			OP_DELETE: begin
				if (above_slot || at_slot) begin
					entry_q <= right_entry;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;
	assign match = occupied && (entry_q == ctrl.data);

endmodule

// ----- rtl/positional_array_list_unit.sv -----
// path: an accepted request goes through the request stage registers and then the result register
// throughput: one request per cycle while req_stall is low; every cell shifts and compares in the accept cycle
// find: the row of match flags is registered and priority encoded in the result stage
// reset: clears the count and empties the pipeline; stored entries keep no reset
module positional_array_list_unit #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [pal_pkg::REQ_W-1:0]           req_type,
	input  logic [pal_pkg::POS_W-1:0]           position,
	input  logic signed [pal_pkg::VAL_W-1:0]    value,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [pal_pkg::STAT_W-1:0]          status,
	output logic [pal_pkg::IDX_W-1:0]           found_index,
	output logic [pal_pkg::LEN_W-1:0]           length
);
	import pal_pkg::*;

	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned IW   = $clog2(CAPACITY);
	localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam int unsigned IXW  = (IW > IDX_W) ? IW : IDX_W;
	localparam int unsigned LXW  = (CW > LEN_W) ? CW : LEN_W;

	logic [CW-1:0]           count_q;
	logic                    accept;
	logic                    rsp_load;
	cell_ctrl_t              ctrl;
	logic [STAT_W-1:0]       status_next;
	logic [CW-1:0]           count_next;
	logic [CMPW-1:0]         pos_ext;
	logic [CMPW-1:0]         cnt_ext;
	logic                    list_full;
	logic                    ins_bad;
	logic                    del_bad;
	logic signed [VAL_W-1:0] cell_entry [CAPACITY];
	logic [CAPACITY-1:0]     cell_match;

	// request stage registers
	logic                    valid_s1;
	logic                    find_s1;
	logic [STAT_W-1:0]       status_s1;
	logic [CAPACITY-1:0]     match_s1;
	logic [CW-1:0]           length_s1;

	// result registers
	logic                    rsp_valid_q;
	logic [STAT_W-1:0]       status_q;
	logic [IDX_W-1:0]        found_index_q;
	logic [LEN_W-1:0]        length_q;

	// result stage decode
	logic [CAPACITY-1:0]     first_hit;
	logic [IXW-1:0]          hit_index;
	logic [LXW-1:0]          length_wide;

	// handshake: the result register parts the two sides
	assign rsp_load  = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !rsp_load;
	assign accept    = req_valid && !req_stall;

	// range checks on the requested position
	assign pos_ext   = CMPW'(position);
	assign cnt_ext   = CMPW'(count_q);
	assign list_full = count_q >= CW'(CAPACITY);
	assign ins_bad   = (position == '0) || (pos_ext > cnt_ext + CMPW'(1));
	assign del_bad   = (position == '0) || (pos_ext > cnt_ext);

	// decode the request into chain control, status and new count
	always_comb begin
		ctrl.op     = OP_HOLD;
		ctrl.slot   = position - POS_W'(1);
		ctrl.data   = value;
		status_next = ST_OK;
		count_next  = count_q;
		unique case (req_type)
			REQ_INSERT: begin
				if (list_full) begin
					status_next = ST_FULL;
				end else if (ins_bad) begin
					status_next = ST_BADPOS;
				end else begin
					ctrl.op    = accept ? OP_INSERT : OP_HOLD;
					count_next = count_q + CW'(1);
				end
			end
			REQ_DELETE: begin
				if (del_bad) begin
					status_next = ST_BADPOS;
				end else begin
					ctrl.op    = accept ? OP_DELETE : OP_HOLD;
					count_next = count_q - CW'(1);
				end
			end
			default: begin
				status_next = ST_OK;
			end
		endcase
	end

	// chain of storage cells, each trading entries with its neighbors
	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		logic signed [VAL_W-1:0] left_entry;
		logic signed [VAL_W-1:0] right_entry;

		if (j == 0) begin : g_first
			assign left_entry = value;
		end else begin : g_mid_left
			assign left_entry = cell_entry[j-1];
		end

		if (j == CAPACITY - 1) begin : g_last
			assign right_entry = cell_entry[j];
		end else begin : g_mid_right
			assign right_entry = cell_entry[j+1];
		end

		pal_cell #(
			.SLOT (j),
			.CW   (CW)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.count       (count_q),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (cell_entry[j]),
			.match       (cell_match[j])
		);
	end

	// count and request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_next;
				valid_s1 <= 1'b1;
			end else if (rsp_load) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			find_s1   <= (req_type == REQ_FIND);
			status_s1 <= status_next;
			match_s1  <= cell_match;
			length_s1 <= count_next;
		end
	end

	// lowest set match flag and its index
	assign first_hit = match_s1 & (~match_s1 + CAPACITY'(1));

	always_comb begin
		hit_index = '0;
		for (int j = 0; j < CAPACITY; j++) begin
			if (first_hit[j]) begin
				hit_index = hit_index | IXW'(j);
			end
		end
	end

	assign length_wide = LXW'(length_s1);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load && valid_s1) begin
			length_q <= length_wide[LEN_W-1:0];
			if (find_s1) begin
				if (match_s1 != '0) begin
					status_q      <= ST_OK;
					found_index_q <= hit_index[IDX_W-1:0];
				end else begin
					status_q      <= ST_NOTFOUND;
					found_index_q <= '0;
				end
			end else begin
				status_q      <= status_s1;
				found_index_q <= '0;
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign found_index = found_index_q;
	assign length      = length_q;

endmodule

// ----- verif/positional_array_list_tb.sv -----
`timescale 1ns / 100ps

module testbench;
	import pal_pkg::*;

	localparam int LIST_CAP = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 700;
	localparam int HOLD_CYCLES = 80;
	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

	typedef struct {
		logic [REQ_W-1:0]        kind;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] val;
		bit                      drain_first;
	} request_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  idx;
		logic [LEN_W-1:0]  len;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [REQ_W-1:0] req_type = '0;
	logic [POS_W-1:0] position = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [STAT_W-1:0] status;
	logic [IDX_W-1:0] found_index;
	logic [LEN_W-1:0] length;

	request_t pending[$];
	answer_t answers[$];
	logic signed [VAL_W-1:0] list_words [LIST_CAP];
	int list_len = 0;
	int gen_depth = 0;
	int errors = 0;
	int sent = 0;
	int results_taken = 0;
	int quiet = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit req_taken = 1'b0;

	positional_array_list_unit #(.CAPACITY(LIST_CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.position(position),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.found_index(found_index),
		.length(length)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// list behavior: shift on insert and delete, first match on find
	function automatic answer_t apply_request(input logic [REQ_W-1:0] kind,
			input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] val);
		answer_t a;
		int p;
		a.status = ST_OK;
		a.idx = '0;
		p = int'(pos);
		case (kind)
			REQ_INSERT: begin
				if (list_len >= LIST_CAP) begin
					a.status = ST_FULL;
				end else if (p < 1 || p > list_len + 1) begin
					a.status = ST_BADPOS;
				end else begin
					for (int j = list_len; j > p - 1; j--)
						list_words[j] = list_words[j - 1];
					list_words[p - 1] = val;
					list_len++;
				end
			end
			REQ_DELETE: begin
				if (p < 1 || p > list_len) begin
					a.status = ST_BADPOS;
				end else begin
					for (int j = p; j < list_len; j++)
						list_words[j - 1] = list_words[j];
					list_len--;
				end
			end
			REQ_FIND: begin
				a.status = ST_NOTFOUND;
				for (int j = 0; j < list_len; j++) begin
					if (list_words[j] == val) begin
						a.status = ST_OK;
						a.idx = j[IDX_W-1:0];
						break;
					end
				end
			end
			default: ;
		endcase
		a.len = list_len[LEN_W-1:0];
		return a;
	endfunction

	// queue a request and track the list length it leaves behind
	task automatic queue_request(input logic [REQ_W-1:0] kind, input int pos,
			input logic signed [VAL_W-1:0] val, input bit drain_first = 1'b0);
		request_t r;
		r.kind = kind;
		r.pos = pos[POS_W-1:0];
		r.val = val;
		r.drain_first = drain_first;
		pending.push_back(r);
		if (kind == REQ_INSERT && gen_depth < LIST_CAP && pos >= 1 && pos <= gen_depth + 1)
			gen_depth++;
		else if (kind == REQ_DELETE && pos >= 1 && pos <= gen_depth)
			gen_depth--;
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	// request driver, changes inputs on the falling edge
	always @(negedge clk) begin : driver
		request_t nxt;
		bit load;
		load = 1'b0;
		if (!arst_n || (req_valid && !req_taken)) begin
			// hold the stalled transfer
		end else begin
			if (pending.size() != 0) begin
				if (pending[0].drain_first && answers.size() != 0)
					load = 1'b0;
				else if (!(sent >= 300 && sent < 420) && $urandom_range(0, 99) < 26)
					load = 1'b0;
				else
					load = 1'b1;
			end
			if (load) begin
				nxt = pending.pop_front();
				req_type <= nxt.kind;
				position <= nxt.pos;
				value <= nxt.val;
				req_valid <= 1'b1;
				sent++;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result stall: random, one long hold-off, one calm stretch
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_taken >= 150) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (results_taken >= 300 && results_taken < 420) begin
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < 26);
		end
	end

	// monitor: predict on request transfers, compare on result transfers
	always @(posedge clk) begin : monitor
		answer_t want;
		bit moved;
		moved = 1'b0;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_valid && !req_stall;
			if (req_valid && !req_stall) begin
				answers.push_back(apply_request(req_type, position, value));
				moved = 1'b1;
			end
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				moved = 1'b1;
				results_taken++;
				if (answers.size() == 0) begin
					$display("%0t: unexpected result, expected none actual status %0d",
						$time, status);
					errors++;
				end else begin
					want = answers.pop_front();
					check_field("status", int'(want.status), int'(status));
					check_field("found_index", int'(want.idx), int'(found_index));
					check_field("length", int'(want.len), int'(length));
				end
			end
			// watchdog on cycles with no transfer at all
			quiet = moved ? 0 : quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic signed [VAL_W-1:0] pool [8];
		logic signed [VAL_W-1:0] v;
		logic [REQ_W-1:0] kind;
		bit growing;
		int pos;
		int roll;
		int counted;

		pool = '{32'sd0, 32'sd1, -32'sd1, 32'sd5, 32'sh7fffffff, 32'sh80000000,
			32'sd1000, -32'sd77};
		foreach (list_words[i])
			list_words[i] = '0;

		// directed: empty list, bad positions, extremes, full list
		queue_request(REQ_FIND, 0, 32'sd0);
		queue_request(REQ_DELETE, 1, 32'sd0);
		queue_request(REQ_INSERT, 0, 32'sd7);
		queue_request(REQ_INSERT, 2, 32'sd7);
		queue_request(REQ_INSERT, 1, 32'sh80000000);
		queue_request(REQ_INSERT, 2, 32'sh7fffffff);
		queue_request(REQ_INSERT, 1, -32'sd1);
		queue_request(REQ_FIND, 0, 32'sh7fffffff);
		queue_request(REQ_SPARE, 31, -32'sd1);
		queue_request(REQ_DELETE, 31, 32'sd0);
		queue_request(REQ_DELETE, 0, 32'sd0);
		queue_request(REQ_DELETE, 2, 32'sd0);
		for (int i = 0; i < 13; i++)
			queue_request(REQ_INSERT, $urandom_range(1, gen_depth + 1),
				(i % 2) ? 32'sd5 : 32'(i * 3 - 100));
		queue_request(REQ_INSERT, 16, 32'sh0badcafe);
		queue_request(REQ_INSERT, 31, 32'sd9);
		queue_request(REQ_INSERT, 0, 32'sd9);
		queue_request(REQ_FIND, 0, 32'sh0badcafe);
		queue_request(REQ_FIND, 0, 32'sd5);
		queue_request(REQ_DELETE, 17, 32'sd0);
		queue_request(REQ_DELETE, 16, 32'sd0);

		// random: grow and shrink phases picked at random, mostly legal positions
		counted = 0;
		growing = 1'b1;
		while (counted < RANDOM_ITEMS) begin
			if (counted % 40 == 0)
				growing = $urandom_range(0, 99) < 55;
			if ($urandom_range(0, 99) < 2) begin
				queue_request(REQ_SPARE, $urandom_range(0, 31), $urandom);
				continue;
			end
			roll = $urandom_range(0, 99);
			if (growing)
				kind = (roll < 65) ? REQ_INSERT : (roll < 85) ? REQ_FIND : REQ_DELETE;
			else
				kind = (roll < 20) ? REQ_INSERT : (roll < 40) ? REQ_FIND : REQ_DELETE;
			if ($urandom_range(0, 99) < 15)
				pos = $urandom_range(0, 31);
			else if (kind == REQ_DELETE)
				pos = (gen_depth > 0) ? $urandom_range(1, gen_depth) : 1;
			else
				pos = $urandom_range(1, gen_depth + 1);
			if ($urandom_range(0, 99) < 70)
				v = pool[$urandom_range(0, 7)];
			else
				v = $urandom;
			queue_request(kind, pos, v, counted == 450);
			counted++;
		end

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || req_valid)
			@(posedge clk);
		while (answers.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/positional_array_list_unit.sv
verif/positional_array_list_tb.sv
